// ===== rtl/ipv4hrc_pkg.sv =====
// shared types and constants for the ipv4 header receive check
package ipv4hrc_pkg;

    localparam int unsigned FifoDepthDefault = 4;

    localparam logic [3:0] PosFirst    = 4'd0;
    localparam logic [3:0] PosProto    = 4'd4;
    localparam logic [3:0] PosChecksum = 4'd5;
    localparam logic [3:0] PosSrcHi    = 4'd6;
    localparam logic [3:0] PosSrcLo    = 4'd7;
    localparam logic [3:0] PosDstHi    = 4'd8;
    localparam logic [3:0] PosLast     = 4'd9;
    localparam logic [3:0] PosIdle     = 4'd10;

    localparam logic [31:0] BroadcastAddr = 32'hffff_ffff;

    localparam logic [7:0] ProtoIcmp = 8'd1;
    localparam logic [7:0] ProtoTcp  = 8'd6;
    localparam logic [7:0] ProtoUdp  = 8'd17;

    localparam logic [1:0] VerdictAccepted    = 2'd0;
    localparam logic [1:0] VerdictNotForUs    = 2'd1;
    localparam logic [1:0] VerdictBadChecksum = 2'd2;

    localparam logic [1:0] ClassIcmp    = 2'd0;
    localparam logic [1:0] ClassUdp     = 2'd1;
    localparam logic [1:0] ClassTcp     = 2'd2;
    localparam logic [1:0] ClassUnknown = 2'd3;

    // one complete header as seen by the front end
    typedef struct packed {
        logic [15:0] sum;
        logic [15:0] checksum;
        logic [31:0] dst_addr;
        logic [31:0] src_addr;
        logic [7:0]  proto;
    } t_hdr_rec;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [1:0]  pclass;
        logic [7:0]  proto;
        logic [31:0] src_addr;
    } t_result;

endpackage

// ===== rtl/ipv4hrc_front.sv =====
// front end: word position, checksum sum and field capture
module ipv4hrc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [15:0]           i_header_word,
    input  logic                  i_start_of_header,
    output logic                  o_rec_push,
    output ipv4hrc_pkg::t_hdr_rec o_rec
);

    logic [3:0]  r_pos, n_pos;
    logic [15:0] r_sum, n_sum;
    logic [15:0] r_csum;
    logic [15:0] r_dst_hi;
    logic [31:0] r_src;
    logic [7:0]  r_proto;

    logic [3:0]  eff_pos;
    logic        active;
    logic [15:0] sum_base;
    logic [16:0] sum_raw;
    logic [15:0] sum_fold;

    always_comb begin
        eff_pos  = i_start_of_header ? ipv4hrc_pkg::PosFirst : r_pos;
        active   = eff_pos < ipv4hrc_pkg::PosIdle;
        sum_base = (eff_pos == ipv4hrc_pkg::PosFirst) ? 16'd0 : r_sum;
        sum_raw  = {1'b0, sum_base} + {1'b0, i_header_word};
        // end-around carry, cannot overflow 16 bits
        sum_fold = sum_raw[15:0] + {15'd0, sum_raw[16]};
        n_sum    = (eff_pos == ipv4hrc_pkg::PosChecksum) ? sum_base : sum_fold;
        n_pos    = active ? (eff_pos + 4'd1) : r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= ipv4hrc_pkg::PosFirst;
        end else if (i_accept) begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && active) begin
            r_sum <= n_sum;
            case (eff_pos)
                ipv4hrc_pkg::PosProto:    r_proto        <= i_header_word[7:0];
                ipv4hrc_pkg::PosChecksum: r_csum         <= i_header_word;
                ipv4hrc_pkg::PosSrcHi:    r_src[31:16]   <= i_header_word;
                ipv4hrc_pkg::PosSrcLo:    r_src[15:0]    <= i_header_word;
                ipv4hrc_pkg::PosDstHi:    r_dst_hi       <= i_header_word;
                default: begin
                end
            endcase
        end
    end

    assign o_rec_push      = i_accept && (eff_pos == ipv4hrc_pkg::PosLast);
    assign o_rec.sum       = sum_fold;
    assign o_rec.checksum  = r_csum;
    assign o_rec.dst_addr  = {r_dst_hi, i_header_word};
    assign o_rec.src_addr  = r_src;
    assign o_rec.proto     = r_proto;

endmodule

// ===== rtl/ipv4hrc_fifo.sv =====
// short header queue between front end and verdict stage
module ipv4hrc_fifo #(
    parameter int unsigned DEPTH = ipv4hrc_pkg::FifoDepthDefault
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  ipv4hrc_pkg::t_hdr_rec i_wr_data,
    input  logic                  i_rd_en,
    output ipv4hrc_pkg::t_hdr_rec o_rd_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    ipv4hrc_pkg::t_hdr_rec r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          wr_do, rd_do;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_do   = i_wr_en && !o_full;
    assign rd_do   = i_rd_en && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_do) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (rd_do) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (wr_do && !rd_do) begin
                r_count <= r_count + CW'(1);
            end else if (rd_do && !wr_do) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_do) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];

endmodule

// ===== rtl/ipv4hrc_back.sv =====
// back end: address filter, checksum compare, protocol class, result register
module ipv4hrc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [31:0]           i_station_addr,
    input  logic                  i_rec_valid,
    input  ipv4hrc_pkg::t_hdr_rec i_rec,
    output logic                  o_rec_take,
    input  logic                  i_pop,
    output logic                  o_valid,
    output ipv4hrc_pkg::t_result  o_result
);

    logic                 r_valid;
    ipv4hrc_pkg::t_result r_result, n_result;
    logic                 addr_ok;
    logic                 csum_ok;

    always_comb begin
        addr_ok = (i_rec.dst_addr == i_station_addr) ||
                  (i_rec.dst_addr == ipv4hrc_pkg::BroadcastAddr);
        csum_ok = (i_rec.checksum == ~i_rec.sum);
        n_result.pclass   = ipv4hrc_pkg::ClassUnknown;
        n_result.proto    = i_rec.proto;
        n_result.src_addr = i_rec.src_addr;
        if (!addr_ok) begin
            n_result.verdict = ipv4hrc_pkg::VerdictNotForUs;
        end else if (!csum_ok) begin
            n_result.verdict = ipv4hrc_pkg::VerdictBadChecksum;
        end else begin
            n_result.verdict = ipv4hrc_pkg::VerdictAccepted;
            case (i_rec.proto)
                ipv4hrc_pkg::ProtoIcmp: n_result.pclass = ipv4hrc_pkg::ClassIcmp;
                ipv4hrc_pkg::ProtoUdp:  n_result.pclass = ipv4hrc_pkg::ClassUdp;
                ipv4hrc_pkg::ProtoTcp:  n_result.pclass = ipv4hrc_pkg::ClassTcp;
                default:                n_result.pclass = ipv4hrc_pkg::ClassUnknown;
            endcase
        end
    end

    // refill the output register whenever it is free or being drained
    assign o_rec_take = i_rec_valid && (!r_valid || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_rec_take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rec_take) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/ipv4hrc_top.sv =====
// top level of the ipv4 header receive check
// path: the record of a header is written into the header queue by the edge that accepts
// its tenth word, then loaded into the output register when that is free or being popped
// throughput: one header word per cycle while full is low; full follows the header queue
// (FIFO_DEPTH entries) alone
// reset: clears word position (first word taken as word 0), queue, output, station address
module ipv4_header_receive_check_top #(
    parameter int unsigned FIFO_DEPTH = ipv4hrc_pkg::FifoDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_header_word,
    input  logic        i_start_of_header,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_verdict,
    output logic [1:0]  o_protocol_class,
    output logic [7:0]  o_protocol_number,
    output logic [31:0] o_source_address
);

    logic [31:0]           r_station_addr;
    logic                  accept;
    logic                  rec_push;
    ipv4hrc_pkg::t_hdr_rec rec_in, rec_head;
    logic                  fifo_full, fifo_empty;
    logic                  rec_take;
    logic                  out_valid;
    ipv4hrc_pkg::t_result  result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_addr <= '0;
        end else if (i_cfg_wr_en) begin
            r_station_addr <= i_cfg_wr_data;
        end
    end

    assign full   = fifo_full;
    assign accept = push && !fifo_full;

    ipv4hrc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_header_word     (i_header_word),
        .i_start_of_header (i_start_of_header),
        .o_rec_push        (rec_push),
        .o_rec             (rec_in)
    );

    ipv4hrc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (rec_push),
        .i_wr_data (rec_in),
        .i_rd_en   (rec_take),
        .o_rd_data (rec_head),
        .o_full    (fifo_full),
        .o_empty   (fifo_empty)
    );

    ipv4hrc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_station_addr (r_station_addr),
        .i_rec_valid    (!fifo_empty),
        .i_rec          (rec_head),
        .o_rec_take     (rec_take),
        .i_pop          (pop && out_valid),
        .o_valid        (out_valid),
        .o_result       (result)
    );

    assign empty             = !out_valid;
    assign o_verdict         = result.verdict;
    assign o_protocol_class  = result.pclass;
    assign o_protocol_number = result.proto;
    assign o_source_address  = result.src_addr;

endmodule
